// File: hdl/i2a_pkg.sv
// Shared types, character codes and helpers for the integer to ASCII digits block.
package i2a_pkg;

	localparam int MAX_VALUE_BITS = 64;
	localparam int DEF_VALUE_BITS = 64;
	localparam int HEX_MAX_DIGITS = 16;

	localparam logic [1:0] ACT_UNSIGNED = 2'd0;
	localparam logic [1:0] ACT_SIGNED   = 2'd1;
	localparam logic [1:0] ACT_HEX      = 2'd2;

	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_LETTER_A = 8'h41;
	localparam logic [3:0] DEC_BASE    = 4'd10;

	typedef struct packed {
		logic [1:0]                action;
		logic [MAX_VALUE_BITS-1:0] value;
		logic [4:0]                hex_digits;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last;
	} chr_item_t;

	typedef struct packed {
		logic                      is_hex;
		logic                      neg;
		logic [MAX_VALUE_BITS-1:0] mag;
		logic [3:0]                top_nib;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CONV,
		B_SIGN,
		B_DEC,
		B_HEX
	} back_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib >= DEC_BASE) begin
			c = CH_LETTER_A + 8'(nib - DEC_BASE);
		end else begin
			c = CH_ZERO + 8'(nib);
		end
		return c;
	endfunction

endpackage

// File: hdl/i2a_front.sv
// Front part: accepts command items, drops undefined actions, forms the magnitude.
module i2a_front #(
	parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  i2a_pkg::cmd_item_t cmd,
	input  logic               full,
	output logic               push,
	output i2a_pkg::job_t      job
);
	import i2a_pkg::*;

	localparam logic [MAX_VALUE_BITS-1:0] MASK =
		MAX_VALUE_BITS'((65'd1 << VALUE_BITS) - 65'd1);

	logic [MAX_VALUE_BITS-1:0] v;
	logic [MAX_VALUE_BITS-1:0] negv;
	logic                      sgn;
	logic [4:0]                cnt;

	always_comb begin
		v    = cmd.value & MASK;
		negv = (~v + MAX_VALUE_BITS'(1)) & MASK;
		sgn  = v[VALUE_BITS-1];
		if (cmd.hex_digits == 5'd0) begin
			cnt = 5'd1;
		end else if (cmd.hex_digits > 5'(HEX_MAX_DIGITS)) begin
			cnt = 5'(HEX_MAX_DIGITS);
		end else begin
			cnt = cmd.hex_digits;
		end
	end

	assign cmd_stall = full;

	always_comb begin
		job.is_hex  = (cmd.action == ACT_HEX);
		job.neg     = (cmd.action == ACT_SIGNED) && sgn;
		job.mag     = job.neg ? negv : v;
		job.top_nib = 4'(cnt - 5'd1);
		push        = cmd_valid && !full &&
			(cmd.action == ACT_UNSIGNED || cmd.action == ACT_SIGNED ||
			 cmd.action == ACT_HEX);
	end

endmodule

// File: hdl/i2a_queue.sv
// Two-entry queue of classified jobs between the front and back parts.
module i2a_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  i2a_pkg::job_t push_job,
	output logic          full,
	output logic          avail,
	input  logic          pop,
	output i2a_pkg::job_t head
);
	import i2a_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: hdl/i2a_back.sv
// Back part: shift-add-3 conversion, digit and nibble emission, output register.
module i2a_back #(
	parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  i2a_pkg::job_t      head,
	output logic               pop,
	output logic               chr_valid,
	input  logic               chr_stall,
	output i2a_pkg::chr_item_t chr
);
	import i2a_pkg::*;

	localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * DEC_DIGITS;
	localparam int BIT_W      = $clog2(VALUE_BITS);
	localparam int DIG_W      = $clog2(DEC_DIGITS);

	back_state_t               state_q, state_d;
	logic [VALUE_BITS-1:0]     mag_q;
	logic [BCD_W-1:0]          bcd_q;
	logic [BCD_W-1:0]          bcd_adj;
	logic [BIT_W-1:0]          bit_q;
	logic [DIG_W-1:0]          dig_q;
	logic                      started_q;
	logic                      neg_q;
	logic [MAX_VALUE_BITS-1:0] hex_q;
	logic [3:0]                nib_q;
	logic [3:0]                top_dig;
	logic                      out_free;
	logic                      emit;
	chr_item_t                 emit_item;
	logic                      load;
	logic                      conv_step;
	logic                      dec_shift;
	logic                      hex_step;
	logic                      chr_valid_q;
	chr_item_t                 chr_q;

	assign out_free  = !chr_valid_q || !chr_stall;
	assign top_dig   = bcd_q[BCD_W-1 -: 4];
	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

	always_comb begin
		for (int d = 0; d < DEC_DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_item = '{ascii_char: CH_ZERO, last: 1'b0};
		load      = 1'b0;
		conv_step = 1'b0;
		dec_shift = 1'b0;
		hex_step  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (avail) begin
					pop     = 1'b1;
					load    = 1'b1;
					state_d = head.is_hex ? B_HEX : B_CONV;
				end
			end
			B_CONV: begin
				conv_step = 1'b1;
				if (bit_q == '0) begin
					state_d = neg_q ? B_SIGN : B_DEC;
				end
			end
			B_SIGN: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{ascii_char: CH_MINUS, last: 1'b0};
					state_d   = B_DEC;
				end
			end
			B_DEC: begin
				if (started_q || top_dig != 4'd0 || dig_q == '0) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_item = '{ascii_char: CH_ZERO + 8'(top_dig),
							last: (dig_q == '0)};
						dec_shift = 1'b1;
						if (dig_q == '0) begin
							state_d = B_IDLE;
						end
					end
				end else begin
					dec_shift = 1'b1;
				end
			end
			B_HEX: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_item = '{ascii_char: hex_char(hex_q[4*nib_q +: 4]),
						last: (nib_q == 4'd0)};
					hex_step  = 1'b1;
					if (nib_q == 4'd0) begin
						state_d = B_IDLE;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			chr_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				chr_valid_q <= 1'b1;
			end else if (!chr_stall) begin
				chr_valid_q <= 1'b0;
			end
			if (load) begin
				started_q <= 1'b0;
			end else if (emit && state_q == B_DEC) begin
				started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			chr_q <= emit_item;
		end
		if (load) begin
			mag_q <= head.mag[VALUE_BITS-1:0];
			hex_q <= head.mag;
			nib_q <= head.top_nib;
			neg_q <= head.neg;
			bcd_q <= '0;
			bit_q <= BIT_W'(VALUE_BITS - 1);
			dig_q <= DIG_W'(DEC_DIGITS - 1);
		end
		if (conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bit_q <= bit_q - BIT_W'(1);
		end
		if (dec_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
			dig_q <= dig_q - DIG_W'(1);
		end
		if (hex_step) begin
			nib_q <= nib_q - 4'd1;
		end
	end

endmodule

// File: hdl/integer_to_ascii_digits_top.sv
// Top level of the integer to ASCII digits converter.
// Each command item carries a VALUE_BITS-wide operand and an action: unsigned decimal,
// signed decimal (leading '-' when negative) or uppercase hex of the low hex_digits
// nibbles (0 gives one, above 16 gives 16); action 3 is accepted and yields nothing.
// Characters leave one per item on the chr channel, the final one of an operand marked
// by last. A decimal operand goes through the bit-serial shift-add-3 converter, then
// out one decimal digit position at a time (20 at 64 bits, leading zeros skipped
// without output), after a '-' when negative. A hex operand goes out one nibble at a
// time. A two-entry job queue lets the command side keep accepting while the converter
// works and the output register waits.
module integer_to_ascii_digits_top #(
	parameter int VALUE_BITS = i2a_pkg::DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  i2a_pkg::cmd_item_t cmd,
	output logic               chr_valid,
	input  logic               chr_stall,
	output i2a_pkg::chr_item_t chr
);
	import i2a_pkg::*;

	logic push;
	job_t push_job;
	logic full;
	logic avail;
	logic pop;
	job_t head;

	i2a_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.full      (full),
		.push      (push),
		.job       (push_job)
	);

	i2a_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.avail    (avail),
		.pop      (pop),
		.head     (head)
	);

	i2a_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

endmodule

// File: hdl/i2a_checker.sv
// Port-level checks for the integer to ASCII digits converter, bound to the top level.
module i2a_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input i2a_pkg::cmd_item_t cmd,
	input logic               chr_valid,
	input logic               chr_stall,
	input i2a_pkg::chr_item_t chr
);
	import i2a_pkg::*;

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("cmd item changed while stalled");

	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_stall |=> chr_valid && $stable(chr))
		else $error("chr item changed while stalled");

	a_chr_set: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid |-> (chr.ascii_char == CH_MINUS) ||
			(chr.ascii_char >= CH_ZERO && chr.ascii_char <= CH_ZERO + 8'd9) ||
			(chr.ascii_char >= CH_LETTER_A && chr.ascii_char <= CH_LETTER_A + 8'd5))
		else $error("character outside the output set");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr.ascii_char == CH_MINUS |-> !chr.last)
		else $error("sign flagged as final character");

endmodule

bind integer_to_ascii_digits_top i2a_checker u_i2a_checker (.*);
